>>> rtl/dws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_pkg
// Shared codes and controller/datapath interface types for the sorting deque.
// ----------------------------------------------------------------------------
package dws_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef enum logic [2:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_POP_FRONT  = 3'd1,
      REQ_POP_BACK   = 3'd2,
      REQ_PUSH_FRONT = 3'd3,
      REQ_SORT       = 3'd4
   } dws_req_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } dws_status_type;

   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_PUSH_BACK  = 4'd1,
      OP_PUSH_FRONT = 4'd2,
      OP_POP_FRONT  = 4'd3,
      OP_POP_BACK   = 4'd4,
      OP_SORT_RDI   = 4'd5,
      OP_SORT_LDI   = 4'd6,
      OP_SORT_CMP   = 4'd7,
      OP_SORT_WRI   = 4'd8
   } dws_op_type;

   typedef struct packed {
      dws_op_type     op;
      logic           latch;
      logic           pop_sel;
      dws_status_type res_status;
      logic           rsp_load;
   } dws_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic cnt_lt2;
      logic i_last;
      logic j_last;
      logic swap;
      logic out_free;
   } dws_sts_type;

endpackage

>>> rtl/dws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_ctrl
// Request decoder and sequencer: one transaction at a time, sort loop control.
// ----------------------------------------------------------------------------
module dws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_type,
   input  dws_pkg::dws_sts_type sts,
   output dws_pkg::dws_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RESP = 6'b000010,
      S_RDI  = 6'b000100,
      S_LDI  = 6'b001000,
      S_CMP  = 6'b010000,
      S_WRI  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd.op         = dws_pkg::OP_NONE;
      cmd.latch      = 1'b0;
      cmd.pop_sel    = 1'b0;
      cmd.res_status = dws_pkg::ST_OK;
      cmd.rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_RESP;
               unique case (dws_pkg::dws_req_type'(req_type))
                  dws_pkg::REQ_PUSH_BACK: begin
                     if (sts.full) cmd.res_status = dws_pkg::ST_FULL;
                     else          cmd.op = dws_pkg::OP_PUSH_BACK;
                  end
                  dws_pkg::REQ_PUSH_FRONT: begin
                     if (sts.full) cmd.res_status = dws_pkg::ST_FULL;
                     else          cmd.op = dws_pkg::OP_PUSH_FRONT;
                  end
                  dws_pkg::REQ_POP_FRONT: begin
                     if (sts.empty) begin
                        cmd.res_status = dws_pkg::ST_EMPTY;
                     end else begin
                        cmd.op      = dws_pkg::OP_POP_FRONT;
                        cmd.pop_sel = 1'b1;
                     end
                  end
                  dws_pkg::REQ_POP_BACK: begin
                     if (sts.empty) begin
                        cmd.res_status = dws_pkg::ST_EMPTY;
                     end else begin
                        cmd.op      = dws_pkg::OP_POP_BACK;
                        cmd.pop_sel = 1'b1;
                     end
                  end
                  dws_pkg::REQ_SORT: begin
                     if (!sts.cnt_lt2) state_in = S_RDI;
                  end
                  default: ;
               endcase
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RDI: begin
            cmd.op   = dws_pkg::OP_SORT_RDI;
            state_in = S_LDI;
         end
         S_LDI: begin
            cmd.op   = dws_pkg::OP_SORT_LDI;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.op = dws_pkg::OP_SORT_CMP;
            if (sts.j_last) state_in = S_WRI;
         end
         S_WRI: begin
            cmd.op   = dws_pkg::OP_SORT_WRI;
            state_in = sts.i_last ? S_RESP : S_RDI;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/dws_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_dpath
// Circular element store, head/count pointers, sort registers, result register.
// ----------------------------------------------------------------------------
module dws_dpath #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dws_pkg::dws_cmd_type           cmd,
   output dws_pkg::dws_sts_type           sts,
   input  logic [dws_pkg::VALUE_W-1:0]    push_value,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [dws_pkg::VALUE_W-1:0]    pop_value,
   output logic [$clog2(DEPTH+1)-1:0]     count_after,
   output logic [1:0]                     status
);

   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned VW     = dws_pkg::VALUE_W;

   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] h,
                                                 input logic [ADDR_W:0]   pos);
      logic [ADDR_W:0] sum;
      sum = {1'b0, h} + pos;
      if (sum >= (ADDR_W+1)'(DEPTH)) sum = sum - (ADDR_W+1)'(DEPTH);
      return sum[ADDR_W-1:0];
   endfunction

   logic [VW-1:0]        mem [DEPTH];
   logic [VW-1:0]        rd_data_ff;
   logic                 rd_en, wr_en;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic [VW-1:0]        wr_data;

   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ADDR_W-1:0]    i_ff, i_in, j_ff, j_in;
   logic signed [VW-1:0] ai_ff, ai_in;
   logic                 pop_sel_ff, pop_sel_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_pop_ff, rsp_pop_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    head_dec, head_inc;

   assign head_dec = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - ADDR_W'(1);
   assign head_inc = (head_ff == ADDR_W'(DEPTH - 1)) ? '0 : head_ff + ADDR_W'(1);

   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == CNT_W'(DEPTH));
   assign sts.cnt_lt2  = (count_ff < CNT_W'(2));
   assign sts.i_last   = (CNT_W'(i_ff) == count_ff - CNT_W'(2));
   assign sts.j_last   = (CNT_W'(j_ff) == count_ff - CNT_W'(1));
   assign sts.swap     = (ai_ff > $signed(rd_data_ff));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = head_ff;
      wr_addr       = head_ff;
      wr_data       = push_value;
      head_in       = head_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      ai_in         = ai_ff;
      pop_sel_in    = pop_sel_ff;
      res_status_in = res_status_ff;
      if (cmd.latch) begin
         pop_sel_in    = cmd.pop_sel;
         res_status_in = cmd.res_status;
         i_in          = '0;
      end
      case (cmd.op)
         dws_pkg::OP_PUSH_BACK: begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(head_ff, (ADDR_W+1)'(count_ff));
            count_in = count_ff + CNT_W'(1);
         end
         dws_pkg::OP_PUSH_FRONT: begin
            wr_en    = 1'b1;
            wr_addr  = head_dec;
            head_in  = head_dec;
            count_in = count_ff + CNT_W'(1);
         end
         dws_pkg::OP_POP_FRONT: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            head_in  = head_inc;
            count_in = count_ff - CNT_W'(1);
         end
         dws_pkg::OP_POP_BACK: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, (ADDR_W+1)'(count_ff - CNT_W'(1)));
            count_in = count_ff - CNT_W'(1);
         end
         dws_pkg::OP_SORT_RDI: begin
            rd_en   = 1'b1;
            rd_addr = slot_of(head_ff, (ADDR_W+1)'(i_ff));
         end
         dws_pkg::OP_SORT_LDI: begin
            ai_in   = $signed(rd_data_ff);
            j_in    = i_ff + ADDR_W'(1);
            rd_en   = 1'b1;
            rd_addr = slot_of(head_ff, (ADDR_W+1)'(i_ff) + (ADDR_W+1)'(1));
         end
         dws_pkg::OP_SORT_CMP: begin
            if (sts.swap) begin
               wr_en   = 1'b1;
               wr_addr = slot_of(head_ff, (ADDR_W+1)'(j_ff));
               wr_data = ai_ff;
               ai_in   = $signed(rd_data_ff);
            end
            rd_en   = 1'b1;
            rd_addr = slot_of(head_ff, (ADDR_W+1)'(j_ff) + (ADDR_W+1)'(1));
            j_in    = j_ff + ADDR_W'(1);
         end
         dws_pkg::OP_SORT_WRI: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, (ADDR_W+1)'(i_ff));
            wr_data = ai_ff;
            i_in    = i_ff + ADDR_W'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pop_in    = rsp_pop_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_pop_in    = pop_sel_ff ? rd_data_ff : '0;
         rsp_count_in  = count_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      ai_ff         <= ai_in;
      pop_sel_ff    <= pop_sel_in;
      res_status_ff <= res_status_in;
      rsp_pop_ff    <= rsp_pop_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign pop_value   = rsp_pop_ff;
   assign count_after = rsp_count_ff;
   assign status      = rsp_status_ff;

endmodule

>>> rtl/deque_with_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_sort
// Double-ended queue of signed 32-bit values with an in-place ascending sort.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one transaction per request. tuser carries the request kind
//   (push back, pop front, pop back, push front, sort), tdata the push value.
//   rsp_*: one transaction per request, in order: popped value, count after
//   the request, and a status in tuser (ok, pop on empty, push on full).
// Flow:
//   Push/pop: the idle step accepts the request and accesses the store; the
//   response step then loads the result register once that register is free.
//   Sort of n entries: per outer index a read, a load, then one inner compare
//   per cycle over the store's single read and write port, then a write-back.
//   One request is in flight at a time; req_tready is high only when idle.
// Reset: empties the queue (head and count to zero); stored data is unchanged
//   and never used before it is written. No clearing pass is needed.
// Stall: a held result stays in the output register; the block finishes the
//   next request and waits in its response step until rsp_tready frees it.
// ----------------------------------------------------------------------------
module deque_with_sort #(
   parameter int unsigned DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [((32 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] rsp_tdata,
                                    // [31:0] pop_value, then count_after, zero fill
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned RSP_W = ((32 + CNT_W + 7) / 8) * 8;

   dws_pkg::dws_cmd_type cmd;
   dws_pkg::dws_sts_type sts;
   logic [31:0]          pop_value;
   logic [CNT_W-1:0]     count_after;

   dws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_type  (req_tuser),
      .sts       (sts),
      .cmd       (cmd)
   );

   dws_dpath #(.DEPTH(DEPTH)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .push_value  (req_tdata),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .pop_value   (pop_value),
      .count_after (count_after),
      .status      (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({count_after, pop_value});

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == dws_pkg::OP_PUSH_BACK || cmd.op == dws_pkg::OP_PUSH_FRONT)
      |-> !sts.full)
      else $error("push issued to a full store");

   a_sort_min_two: assert property (@(posedge clock) disable iff (reset)
      cmd.op == dws_pkg::OP_SORT_CMP |-> !sts.cnt_lt2)
      else $error("sort compare with fewer than two entries");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_tvalid)
      else $error("result load did not raise rsp_tvalid");
`endif

endmodule

>>> tb/sv/deque_with_sort_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_sort_tb
// Self-checking bench for the sorting deque. A shadow deque in the scoreboard
// tracks head, count and contents, and predicts each response as requests are
// accepted. Directed requests cover empty pops, the value extremes, front wrap,
// unused request codes and small sorts. A fill to capacity with dropped pushes
// and a full-size sort follows, then random traffic under three handshake
// idling mixes on both sides.
// ----------------------------------------------------------------------------
module deque_with_sort_tb;

   localparam int unsigned QUEUE_DEPTH    = 256;
   localparam int unsigned COUNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned RSP_W          = ((32 + COUNT_W + 7) / 8) * 8;
   localparam int unsigned SORT_SIZE_CAP  = 48;
   localparam int unsigned WATCHDOG_LIMIT = 200000;

   localparam logic [2:0] REQ_SPARE_A = 3'd5;
   localparam logic [2:0] REQ_SPARE_B = 3'd6;
   localparam logic [2:0] REQ_SPARE_C = 3'd7;

   typedef struct {
      logic [31:0]             pop_value;
      logic [COUNT_W-1:0]      count_after;
      dws_pkg::dws_status_type status;
   } deque_result_type;

   class deque_scoreboard;
      logic [31:0]      contents [QUEUE_DEPTH];
      int unsigned      head;
      int unsigned      count;
      deque_result_type expected_q [$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      dropped_pushes;
      int unsigned      empty_pops;
      int unsigned      sorts;
      int unsigned      largest_sort;

      function new();
         head           = 0;
         count          = 0;
         errors         = 0;
         checked        = 0;
         dropped_pushes = 0;
         empty_pops     = 0;
         sorts          = 0;
         largest_sort   = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void sort_contents();
         int unsigned sa;
         int unsigned sb;
         logic [31:0] swap_tmp;
         for (int unsigned i = 0; i + 1 < count; i++) begin
            for (int unsigned j = i + 1; j < count; j++) begin
               sa = (head + i) % QUEUE_DEPTH;
               sb = (head + j) % QUEUE_DEPTH;
               if ($signed(contents[sa]) > $signed(contents[sb])) begin
                  swap_tmp     = contents[sa];
                  contents[sa] = contents[sb];
                  contents[sb] = swap_tmp;
               end
            end
         end
      endfunction

      function void note_request(logic [2:0] kind, logic [31:0] value);
         deque_result_type r;
         r.pop_value = '0;
         r.status    = dws_pkg::ST_OK;
         case (kind)
            dws_pkg::REQ_PUSH_BACK, dws_pkg::REQ_PUSH_FRONT: begin
               if (count >= QUEUE_DEPTH) begin
                  r.status = dws_pkg::ST_FULL;
                  dropped_pushes++;
               end else if (kind == dws_pkg::REQ_PUSH_BACK) begin
                  contents[(head + count) % QUEUE_DEPTH] = value;
                  count++;
               end else begin
                  head           = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                  contents[head] = value;
                  count++;
               end
            end
            dws_pkg::REQ_POP_FRONT, dws_pkg::REQ_POP_BACK: begin
               if (count == 0) begin
                  r.status = dws_pkg::ST_EMPTY;
                  empty_pops++;
               end else if (kind == dws_pkg::REQ_POP_FRONT) begin
                  r.pop_value = contents[head];
                  head        = (head + 1) % QUEUE_DEPTH;
                  count--;
               end else begin
                  r.pop_value = contents[(head + count - 1) % QUEUE_DEPTH];
                  count--;
               end
            end
            dws_pkg::REQ_SORT: begin
               sort_contents();
               sorts++;
               if (count > largest_sort) largest_sort = count;
            end
            default: ;
         endcase
         r.count_after = count[COUNT_W-1:0];
         expected_q.push_back(r);
      endfunction

      function void check_response(logic [31:0] pop_value, logic [COUNT_W-1:0] count_after,
                                   logic [1:0] status);
         deque_result_type r;
         if (expected_q.size() == 0) begin
            $error("unexpected response transaction: pop_value %0d count_after %0d status %0d",
                   $signed(pop_value), count_after, status);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         checked++;
         if (pop_value !== r.pop_value) begin
            $error("pop_value: expected %0d, got %0d", $signed(r.pop_value), $signed(pop_value));
            errors++;
         end
         if (count_after !== r.count_after) begin
            $error("count_after: expected %0d, got %0d", r.count_after, count_after);
            errors++;
         end
         if (status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, status);
            errors++;
         end
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;
   logic [2:0]        req_tuser  = dws_pkg::REQ_PUSH_BACK;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [1:0]        rsp_tuser;

   deque_scoreboard scoreboard = new();
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   int unsigned     issued        = 0;
   int unsigned     idle_cycles   = 0;

   deque_with_sort #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         scoreboard.check_response(rsp_tdata[31:0], rsp_tdata[32 +: COUNT_W], rsp_tuser);
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [31:0] random_value();
      case ($urandom_range(9))
         0, 1, 2: return 32'($signed($urandom_range(7)) - 4);
         3:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Called at a rising edge; returns at the edge that accepts the transaction.
   task automatic send_request(input logic [2:0] kind, input logic [31:0] value);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scoreboard.note_request(kind, value);
      issued++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending() != 0);
   endtask

   task automatic send_random_request();
      int unsigned roll;
      logic [2:0]  kind;
      roll = $urandom_range(99);
      if (scoreboard.count <= SORT_SIZE_CAP) begin
         if (roll < 28)      kind = dws_pkg::REQ_PUSH_BACK;
         else if (roll < 52) kind = dws_pkg::REQ_PUSH_FRONT;
         else if (roll < 70) kind = dws_pkg::REQ_POP_FRONT;
         else if (roll < 88) kind = dws_pkg::REQ_POP_BACK;
         else if (roll < 95) kind = dws_pkg::REQ_SORT;
         else                kind = 3'($urandom_range(REQ_SPARE_C, REQ_SPARE_A));
      end else begin
         if (roll < 20)      kind = dws_pkg::REQ_PUSH_BACK;
         else if (roll < 40) kind = dws_pkg::REQ_PUSH_FRONT;
         else if (roll < 65) kind = dws_pkg::REQ_POP_FRONT;
         else if (roll < 90) kind = dws_pkg::REQ_POP_BACK;
         else                kind = 3'($urandom_range(REQ_SPARE_C, REQ_SPARE_A));
      end
      send_request(kind, random_value());
   endtask

   task automatic pop_until(input int unsigned floor_count);
      while (scoreboard.count > floor_count)
         send_request($urandom_range(1) ? dws_pkg::REQ_POP_FRONT : dws_pkg::REQ_POP_BACK,
                      random_value());
   endtask

   // Fill to capacity, push into the full queue, sort it whole, then empty it.
   task automatic fill_sort_drain();
      while (scoreboard.count < QUEUE_DEPTH)
         send_request($urandom_range(1) ? dws_pkg::REQ_PUSH_BACK : dws_pkg::REQ_PUSH_FRONT,
                      random_value());
      repeat (3)
         send_request($urandom_range(1) ? dws_pkg::REQ_PUSH_BACK : dws_pkg::REQ_PUSH_FRONT,
                      random_value());
      send_request(dws_pkg::REQ_SORT, random_value());
      pop_until(0);
      send_request(dws_pkg::REQ_POP_FRONT, random_value());
      send_request(dws_pkg::REQ_POP_BACK, random_value());
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned n_items, input bit with_fill);
      int unsigned stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at       = issued + n_items;
      if (with_fill) fill_sort_drain();
      while (issued < stop_at) begin
         if ($urandom_range(99) < 2) begin
            pop_until(0);
            send_request($urandom_range(1) ? dws_pkg::REQ_POP_FRONT : dws_pkg::REQ_POP_BACK,
                         random_value());
         end else begin
            send_random_request();
         end
      end
      drain_results();
   endtask

   initial begin
      send_idle_pct = 21;
      recv_idle_pct = 80;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(dws_pkg::REQ_POP_FRONT,  32'h0000_0000);
      send_request(dws_pkg::REQ_POP_BACK,   32'hFFFF_FFFF);
      send_request(dws_pkg::REQ_SORT,       32'h0000_0000);
      send_request(REQ_SPARE_A,             32'hFFFF_FFFF);
      send_request(dws_pkg::REQ_PUSH_BACK,  32'h7FFF_FFFF);
      send_request(dws_pkg::REQ_SORT,       32'h0000_0000);
      send_request(dws_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
      send_request(dws_pkg::REQ_PUSH_BACK,  32'h0000_0000);
      send_request(dws_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
      send_request(dws_pkg::REQ_PUSH_BACK,  32'h0000_0001);
      send_request(dws_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(REQ_SPARE_B,             32'h5555_5555);
      send_request(dws_pkg::REQ_SORT,       32'hAAAA_AAAA);
      send_request(dws_pkg::REQ_POP_FRONT,  32'h0000_0000);
      send_request(dws_pkg::REQ_POP_BACK,   32'h0000_0000);
      send_request(REQ_SPARE_C,             32'h0000_0000);
      send_request(dws_pkg::REQ_POP_FRONT,  32'h0000_0000);
      send_request(dws_pkg::REQ_POP_BACK,   32'h0000_0000);
      send_request(dws_pkg::REQ_POP_BACK,   32'h0000_0000);
      send_request(dws_pkg::REQ_POP_FRONT,  32'h0000_0000);
      send_request(dws_pkg::REQ_POP_BACK,   32'h0000_0000);
      drain_results();

      run_phase(21, 80, 600, 1'b1);
      run_phase(80, 21, 550, 1'b0);
      run_phase(0, 0, 550, 1'b0);

      repeat (8) @(posedge clock);
      $display("Ran %0d requests, %0d responses checked: %0d sorts (up to %0d entries),",
               issued, scoreboard.checked, scoreboard.sorts, scoreboard.largest_sort);
      $display("%0d pushes dropped on a full queue, %0d pops on an empty queue.",
               scoreboard.dropped_pushes, scoreboard.empty_pops);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> deque_with_sort.f
rtl/dws_pkg.sv
rtl/dws_ctrl.sv
rtl/dws_dpath.sv
rtl/deque_with_sort.sv
tb/sv/deque_with_sort_tb.sv
